// ===== hw/rtl/mkd_pkg.sv =====
// Shared types, constants and the Morse tree lookup for the Morse key decoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mkd_pkg;

	// Field widths
	localparam int unsigned TICK_W = 4;
	localparam int unsigned GAP_W  = 6;
	localparam int unsigned CODE_W = 5;
	localparam int unsigned WAIT_W = 5;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned DATA_W = 6;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] CFG_SAMPLE_TICKS   = 3'd0;
	localparam logic [IDX_W-1:0] CFG_OVERFLOW_EXTRA = 3'd1;
	localparam logic [IDX_W-1:0] CFG_DASH_ON_TICKS  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_DOT_OFF_TICKS  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_DOT_ON_TICKS   = 3'd4;
	localparam logic [IDX_W-1:0] CFG_LETTER_GAP     = 3'd5;
	localparam logic [IDX_W-1:0] CFG_WORD_GAP       = 3'd6;

	// Register values after reset
	localparam logic [TICK_W-1:0] RST_SAMPLE_TICKS   = 4'd6;
	localparam logic [TICK_W-1:0] RST_OVERFLOW_EXTRA = 4'd10;
	localparam logic [TICK_W-1:0] RST_DASH_ON_TICKS  = 4'd10;
	localparam logic [TICK_W-1:0] RST_DOT_OFF_TICKS  = 4'd8;
	localparam logic [TICK_W-1:0] RST_DOT_ON_TICKS   = 4'd2;
	localparam logic [GAP_W-1:0]  RST_LETTER_GAP     = 6'd15;
	localparam logic [GAP_W-1:0]  RST_WORD_GAP       = 6'd42;

	// Saturation limits
	localparam logic [CODE_W-1:0] CODE_MAX = 5'd31;
	localparam logic [GAP_W-1:0]  GAP_MAX  = 6'd63;

	// Characters
	localparam logic [CHAR_W-1:0] CH_UNKNOWN = 7'h3f;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;

	typedef struct packed {
		logic [TICK_W-1:0] sample_ticks;
		logic [TICK_W-1:0] overflow_extra_ticks;
		logic [TICK_W-1:0] dash_on_ticks;
		logic [TICK_W-1:0] dot_off_ticks;
		logic [TICK_W-1:0] dot_on_ticks;
		logic [GAP_W-1:0]  letter_gap_ticks;
		logic [GAP_W-1:0]  word_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic              led_on;
		logic              char_valid;
		logic [CHAR_W-1:0] char_code;
	} res_t;

	// Binary Morse tree: dot goes to 2i+1, dash to 2i+2
	function automatic logic [CHAR_W-1:0] tree_letter(input logic [CODE_W-1:0] code);
		logic [7:0] ch;
		unique case (code)
			5'd1:    ch = "E";
			5'd2:    ch = "T";
			5'd3:    ch = "I";
			5'd4:    ch = "A";
			5'd5:    ch = "N";
			5'd6:    ch = "M";
			5'd7:    ch = "S";
			5'd8:    ch = "U";
			5'd9:    ch = "R";
			5'd10:   ch = "W";
			5'd11:   ch = "D";
			5'd12:   ch = "K";
			5'd13:   ch = "G";
			5'd14:   ch = "O";
			5'd15:   ch = "H";
			5'd16:   ch = "V";
			5'd17:   ch = "F";
			5'd19:   ch = "L";
			5'd21:   ch = "P";
			5'd22:   ch = "J";
			5'd23:   ch = "B";
			5'd24:   ch = "X";
			5'd25:   ch = "C";
			5'd26:   ch = "Y";
			5'd27:   ch = "Z";
			5'd28:   ch = "Q";
			default: ch = "?";
		endcase
		return ch[CHAR_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/mkd_cfg_regs.sv =====
// Configuration register file of the Morse key decoder.
// Depends on mkd_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module mkd_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [mkd_pkg::IDX_W-1:0]  wr_index,
	input  logic [mkd_pkg::DATA_W-1:0] wr_data,
	output mkd_pkg::cfg_t            cfg
);
	import mkd_pkg::*;

	cfg_t cfg_q;

	// Register writes, data trimmed to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_ticks         <= RST_SAMPLE_TICKS;
			cfg_q.overflow_extra_ticks <= RST_OVERFLOW_EXTRA;
			cfg_q.dash_on_ticks        <= RST_DASH_ON_TICKS;
			cfg_q.dot_off_ticks        <= RST_DOT_OFF_TICKS;
			cfg_q.dot_on_ticks         <= RST_DOT_ON_TICKS;
			cfg_q.letter_gap_ticks     <= RST_LETTER_GAP;
			cfg_q.word_gap_ticks       <= RST_WORD_GAP;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SAMPLE_TICKS:   cfg_q.sample_ticks         <= wr_data[TICK_W-1:0];
				CFG_OVERFLOW_EXTRA: cfg_q.overflow_extra_ticks <= wr_data[TICK_W-1:0];
				CFG_DASH_ON_TICKS:  cfg_q.dash_on_ticks        <= wr_data[TICK_W-1:0];
				CFG_DOT_OFF_TICKS:  cfg_q.dot_off_ticks        <= wr_data[TICK_W-1:0];
				CFG_DOT_ON_TICKS:   cfg_q.dot_on_ticks         <= wr_data[TICK_W-1:0];
				CFG_LETTER_GAP:     cfg_q.letter_gap_ticks     <= wr_data[GAP_W-1:0];
				CFG_WORD_GAP:       cfg_q.word_gap_ticks       <= wr_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/mkd_core.sv =====
// Tick state machine of the Morse key decoder: phases, wait and gap counters,
// symbol code and the per-tick result. Depends on mkd_pkg.
`timescale 1ns / 1ps

module mkd_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          key,
	input  mkd_pkg::cfg_t cfg,
	output mkd_pkg::res_t res
);
	import mkd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SAMPLE,
		PH_DASH_ON,
		PH_DOT_OFF,
		PH_DOT_ON
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [WAIT_W-1:0]   wait_q, wait_d;
	logic [CODE_W-1:0]   sym_q, sym_d;
	logic [GAP_W-1:0]    gap_q, gap_d;
	res_t                res_d;

	logic [WAIT_W-1:0]   wait_dec;
	logic [CODE_W+1:0]   ext_v;
	logic [CODE_W-1:0]   sym_ext;
	logic [WAIT_W-1:0]   total;
	logic                raised;
	logic [GAP_W-1:0]    gap_inc;

	// Shared helpers: countdown, tree extension, press wait, gap increment
	always_comb begin
		wait_dec = (wait_q != '0) ? wait_q - WAIT_W'(1) : wait_q;
		ext_v    = {1'b0, sym_q, 1'b0} + (key ? 7'd2 : 7'd1);
		sym_ext  = (ext_v > 7'(CODE_MAX)) ? CODE_MAX : ext_v[CODE_W-1:0];
		total    = {1'b0, cfg.sample_ticks}
			+ ((sym_q == CODE_MAX) ? {1'b0, cfg.overflow_extra_ticks} : WAIT_W'(0));
		raised   = (gap_q != GAP_MAX);
		gap_inc  = raised ? gap_q + GAP_W'(1) : gap_q;
	end

	// Next state and result of one tick
	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		sym_d   = sym_q;
		gap_d   = gap_q;
		res_d   = '0;
		unique case (phase_q)
			PH_SAMPLE: begin
				wait_d = wait_dec;
				if (wait_dec == '0) begin
					sym_d = sym_ext;
					gap_d = '0;
					if (key) begin
						if (cfg.dash_on_ticks == '0) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_DASH_ON;
							wait_d  = {1'b0, cfg.dash_on_ticks};
						end
					end else if (cfg.dot_off_ticks != '0) begin
						phase_d = PH_DOT_OFF;
						wait_d  = {1'b0, cfg.dot_off_ticks};
					end else if (cfg.dot_on_ticks == '0) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_DOT_ON;
						wait_d  = {1'b0, cfg.dot_on_ticks};
					end
				end
			end
			PH_DOT_OFF: begin
				wait_d = wait_dec;
				if (wait_dec == '0) begin
					if (cfg.dot_on_ticks == '0) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_DOT_ON;
						wait_d  = {1'b0, cfg.dot_on_ticks};
					end
				end
			end
			PH_DASH_ON, PH_DOT_ON: begin
				res_d.led_on = 1'b1;
				wait_d = wait_dec;
				if (wait_dec == '0) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				// idle, and any stray code acts as idle
				phase_d = PH_IDLE;
				if (key) begin
					wait_d  = (total == '0) ? WAIT_W'(1) : total;
					phase_d = PH_SAMPLE;
				end else begin
					gap_d = gap_inc;
					if ((sym_q != '0) && (gap_inc >= cfg.letter_gap_ticks)) begin
						res_d.char_valid = 1'b1;
						res_d.char_code  = (sym_q == CODE_MAX) ? CH_UNKNOWN : tree_letter(sym_q);
						sym_d = '0;
						gap_d = '0;
					end else if (raised && (gap_inc == cfg.word_gap_ticks)) begin
						res_d.char_valid = 1'b1;
						res_d.char_code  = CH_SPACE;
					end
				end
			end
		endcase
	end

	// State update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			sym_q   <= '0;
			gap_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			sym_q   <= sym_d;
			gap_q   <= gap_d;
		end
	end

	assign res = res_d;

`ifndef SYNTH
	// A countdown phase never sits at zero wait
	a_wait_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (wait_q != '0))
		else $error("mkd_core: non-idle phase with zero wait count");

	// A decoded letter always clears the symbol code
	a_letter_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_d.char_valid && (res_d.char_code != CH_SPACE)) |=> (sym_q == '0))
		else $error("mkd_core: symbol code not cleared after a letter");

	// No tick, no state change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(phase_q) && $stable(sym_q) && $stable(gap_q) && $stable(wait_q)))
		else $error("mkd_core: state moved without a tick");
`endif

endmodule

// ===== hw/rtl/morse_key_decoder_unit.sv =====
// Top level of the Morse key decoder: input register, tick state machine,
// result register and configuration registers. Depends on mkd_pkg,
// mkd_cfg_regs and mkd_core.
//
//   port group   direction  handshake           payload
//   in           sink       in_valid / in_stall  key_pressed
//   out          source     out_valid / out_stall led_on, char_valid, char_code
//   cfg          sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; each word passes from the input
// register through mkd_core, and its result lands in the result register.
// Throughput is set by the state update in mkd_core, which steps once per accepted word.
// Reset clears all control state and loads the default register values.
// A stalled result holds; the input side stalls only when both the input
// register and the result register are full and out_stall is high.
`timescale 1ns / 1ps

module morse_key_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        key_pressed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        led_on,
	output logic                        char_valid,
	output logic [mkd_pkg::CHAR_W-1:0]  char_code,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mkd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [mkd_pkg::DATA_W-1:0]  cfg_data
);
	import mkd_pkg::*;

	cfg_t  cfg;
	res_t  res;
	res_t  res_q;
	logic  valid_s1;
	logic  key_s1;
	logic  out_valid_q;
	logic  advance;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	mkd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Word moves on when the result register is empty or being drained
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			key_s1 <= key_pressed;
		end
	end

	mkd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.key    (key_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign led_on     = res_q.led_on;
	assign char_valid = res_q.char_valid;
	assign char_code  = res_q.char_code;

`ifndef SYNTH
	// Input stalls only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("morse_key_decoder_unit: input stalled without output back-pressure");

	// A word that advances always shows up as a result
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("morse_key_decoder_unit: advanced word produced no result");

	// A held word stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(key_s1)))
		else $error("morse_key_decoder_unit: stalled input word lost");
`endif

endmodule

// ===== sim/morse_key_decoder_unit_tb.sv =====
// Self-checking testbench for morse_key_decoder_unit: key samples in, one LED/character
// word out per tick, checked against a tick-level decoder model kept in a scoreboard class.
// Depends on mkd_pkg and the morse_key_decoder_unit RTL.
`timescale 1ns / 1ps

module morse_key_decoder_unit_tb;
	import mkd_pkg::*;

	// Decoder phases as tracked by the scoreboard
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESAMPLE,
		ST_DASH_LIT,
		ST_DOT_DARK,
		ST_DOT_LIT
	} tick_state_t;

	// Tracks decoder state, predicts each tick's word and checks the outputs
	class decoder_scoreboard;
		cfg_t              regs;
		tick_state_t       state;
		logic [WAIT_W-1:0] ticks_left;
		logic [CODE_W-1:0] tree_pos;
		logic [GAP_W-1:0]  released;
		res_t              expected_q[$];
		int                errors;

		function new();
			regs = '{sample_ticks: RST_SAMPLE_TICKS, overflow_extra_ticks: RST_OVERFLOW_EXTRA,
				dash_on_ticks: RST_DASH_ON_TICKS, dot_off_ticks: RST_DOT_OFF_TICKS,
				dot_on_ticks: RST_DOT_ON_TICKS, letter_gap_ticks: RST_LETTER_GAP,
				word_gap_ticks: RST_WORD_GAP};
			state      = ST_IDLE;
			ticks_left = '0;
			tree_pos   = '0;
			released   = '0;
			errors     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				CFG_SAMPLE_TICKS:   regs.sample_ticks = val[TICK_W-1:0];
				CFG_OVERFLOW_EXTRA: regs.overflow_extra_ticks = val[TICK_W-1:0];
				CFG_DASH_ON_TICKS:  regs.dash_on_ticks = val[TICK_W-1:0];
				CFG_DOT_OFF_TICKS:  regs.dot_off_ticks = val[TICK_W-1:0];
				CFG_DOT_ON_TICKS:   regs.dot_on_ticks = val[TICK_W-1:0];
				CFG_LETTER_GAP:     regs.letter_gap_ticks = val[GAP_W-1:0];
				CFG_WORD_GAP:       regs.word_gap_ticks = val[GAP_W-1:0];
				default: ;
			endcase
		endfunction

		// Letter at a tree position; overflowed codes decode as unknown
		function logic [CHAR_W-1:0] letter_at(logic [CODE_W-1:0] pos);
			string tree = "?ETIANMSURWDKGOHVF?L?PJBXCYZQ??";
			byte   ch;
			if (pos >= CODE_MAX)
				return CH_UNKNOWN;
			ch = tree[pos];
			return ch[CHAR_W-1:0];
		endfunction

		// Descend the tree: dot 2i+1, dash 2i+2, saturating
		function void push_element(bit dash);
			int v;
			v = 2 * int'(tree_pos) + (dash ? 2 : 1);
			tree_pos = (v > int'(CODE_MAX)) ? CODE_MAX : v[CODE_W-1:0];
			released = '0;
		endfunction

		// Zero lit time skips straight back to idle
		function void start_lit(tick_state_t st, logic [TICK_W-1:0] n);
			if (n == 0) begin
				state = ST_IDLE;
			end else begin
				state = st;
				ticks_left = WAIT_W'(n);
			end
		endfunction

		// One accepted key sample -> one expected word
		function void note_key(bit key);
			res_t r;
			int   total;
			bit   raised;
			r = '0;
			case (state)
				ST_RESAMPLE: begin
					if (ticks_left != 0)
						ticks_left--;
					if (ticks_left == 0) begin
						if (key) begin
							push_element(1'b1);
							start_lit(ST_DASH_LIT, regs.dash_on_ticks);
						end else begin
							push_element(1'b0);
							if (regs.dot_off_ticks == 0) begin
								start_lit(ST_DOT_LIT, regs.dot_on_ticks);
							end else begin
								state = ST_DOT_DARK;
								ticks_left = WAIT_W'(regs.dot_off_ticks);
							end
						end
					end
				end
				ST_DOT_DARK: begin
					if (ticks_left != 0)
						ticks_left--;
					if (ticks_left == 0)
						start_lit(ST_DOT_LIT, regs.dot_on_ticks);
				end
				ST_DASH_LIT, ST_DOT_LIT: begin
					r.led_on = 1'b1;
					if (ticks_left != 0)
						ticks_left--;
					if (ticks_left == 0)
						state = ST_IDLE;
				end
				default: begin
					state = ST_IDLE;
					if (key) begin
						// press: arm the resample, longer once the code overflowed
						total = int'(regs.sample_ticks);
						if (tree_pos == CODE_MAX)
							total += int'(regs.overflow_extra_ticks);
						ticks_left = (total == 0) ? WAIT_W'(1) : total[WAIT_W-1:0];
						state = ST_RESAMPLE;
					end else begin
						// release: gap count, then letter end or word space
						raised = 1'b0;
						if (released < GAP_MAX) begin
							released++;
							raised = 1'b1;
						end
						if (tree_pos != 0 && released >= regs.letter_gap_ticks) begin
							r.char_valid = 1'b1;
							r.char_code = letter_at(tree_pos);
							tree_pos = '0;
							released = '0;
						end else if (raised && released == regs.word_gap_ticks) begin
							r.char_valid = 1'b1;
							r.char_code = CH_SPACE;
						end
					end
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void complain(string what, res_t want, res_t got);
			errors++;
			if (errors <= 10)
				$display("%0t %s: expected led=%0b valid=%0b char=%h, got led=%0b valid=%0b char=%h",
					$time, what, want.led_on, want.char_valid, want.char_code,
					got.led_on, got.char_valid, got.char_code);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				complain("unexpected word", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.led_on !== want.led_on || got.char_valid !== want.char_valid ||
					got.char_code !== want.char_code)
				complain("mismatch", want, got);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               key_pressed = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               led_on;
	logic               char_valid;
	logic [CHAR_W-1:0]  char_code;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]  cfg_data = '0;

	decoder_scoreboard sb = new();
	res_t word_out;
	bit   tx_idle_on = 1'b0;
	bit   rx_idle_on = 1'b0;
	int   keys_sent = 0;

	assign word_out = {led_on, char_valid, char_code};

	morse_key_decoder_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_pressed (key_pressed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_on      (led_on),
		.char_valid  (char_valid),
		.char_code   (char_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	// Monitors: sample handshakes at the edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_key(key_pressed);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(word_out);
		if (arst_n && cfg_valid && cfg_ready)
			sb.note_write(cfg_index, cfg_data);
	end

	// Receiver back-pressure in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin
		#4000000;
		$display("[morse_key_decoder_unit] ERROR");
		$finish;
	end

	task automatic send_key(input bit k);
		if (tx_idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_pressed <= k;
		do @(posedge clk); while (in_stall);
		keys_sent++;
	endtask

	task automatic key_run(input bit k, input int n);
		repeat (n) send_key(k);
	endtask

	// Hold off until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [DATA_W-1:0] samp, input logic [DATA_W-1:0] extra,
			input logic [DATA_W-1:0] dash_on, input logic [DATA_W-1:0] dot_off,
			input logic [DATA_W-1:0] dot_on, input logic [DATA_W-1:0] letter_gap,
			input logic [DATA_W-1:0] word_gap);
		write_reg(CFG_SAMPLE_TICKS, samp);
		write_reg(CFG_OVERFLOW_EXTRA, extra);
		write_reg(CFG_DASH_ON_TICKS, dash_on);
		write_reg(CFG_DOT_OFF_TICKS, dot_off);
		write_reg(CFG_DOT_ON_TICKS, dot_on);
		write_reg(CFG_LETTER_GAP, letter_gap);
		write_reg(CFG_WORD_GAP, word_gap);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Well-formed letter: dots released before the resample, dashes held past it
	task automatic send_letter();
		int n_el;
		int total;
		int lit;
		int press;
		int gap;
		int samp;
		n_el = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
		samp = int'(sb.regs.sample_ticks);
		total = samp + int'(sb.regs.overflow_extra_ticks);
		if (total == 0)
			total = 1;
		lit = int'(sb.regs.dash_on_ticks) + int'(sb.regs.dot_off_ticks)
			+ int'(sb.regs.dot_on_ticks);
		repeat (n_el) begin
			if ($urandom_range(0, 1) == 1)
				press = total + int'($urandom_range(1, 3));
			else
				press = int'($urandom_range(1, (samp == 0) ? 1 : samp));
			key_run(1'b1, press);
			key_run(1'b0, int'($urandom_range(1, lit + 2)));
		end
		if ($urandom_range(0, 3) == 0)
			gap = int'(sb.regs.word_gap_ticks) + int'($urandom_range(0, 4));
		else
			gap = int'(sb.regs.letter_gap_ticks) + int'($urandom_range(0, 3));
		key_run(1'b0, lit + gap);
	endtask

	function automatic logic [DATA_W-1:0] rand_ticks();
		return ($urandom_range(0, 4) == 0) ? DATA_W'($urandom_range(0, 63))
			: DATA_W'($urandom_range(0, 4));
	endfunction

	initial begin
		int  base;
		int  phase_end;
		int  phase_start;
		int  p;
		bit  paused;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero sample wait, zero dark and lit times, letter end, word space,
		// then five dashes to overflow the code and decode as unknown
		load_settings(0, 0, 1, 0, 0, 2, 3);
		key_run(1'b1, 1);
		key_run(1'b0, 1);
		key_run(1'b0, 2);
		key_run(1'b0, 3);
		repeat (5) begin
			key_run(1'b1, 2);
			key_run(1'b0, 1);
		end
		key_run(1'b0, 2);
		drain();

		// Random phases, each under its own register setting
		base = keys_sent;
		p = 0;
		paused = 1'b0;
		while (keys_sent - base < 900) begin
			case (p)
				0: load_settings(DATA_W'(RST_SAMPLE_TICKS), DATA_W'(RST_OVERFLOW_EXTRA),
					DATA_W'(RST_DASH_ON_TICKS), DATA_W'(RST_DOT_OFF_TICKS),
					DATA_W'(RST_DOT_ON_TICKS), RST_LETTER_GAP, RST_WORD_GAP);
				1: load_settings(15, 15, 15, 15, 15, 62, 62);
				2: load_settings(1, 0, 1, 0, 1, 1, 2);
				default: load_settings(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(),
					rand_ticks(),
					($urandom_range(0, 4) == 0) ? DATA_W'($urandom_range(0, 63))
						: DATA_W'($urandom_range(1, 12)),
					($urandom_range(0, 4) == 0) ? DATA_W'($urandom_range(0, 63))
						: DATA_W'($urandom_range(2, 30)));
			endcase
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			phase_start = keys_sent;
			phase_end = keys_sent + int'($urandom_range(100, 200));
			while (keys_sent < phase_end && keys_sent - base < 900) begin
				// quiet tail: no idling on either side
				if (keys_sent - base > 780) begin
					tx_idle_on = 1'b0;
					rx_idle_on = 1'b0;
				end
				if (p == 2 && !paused && keys_sent > phase_start + 40) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 24)) send_key(1'($urandom_range(0, 1)));
				else
					send_letter();
			end
			drain();
			p++;
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[morse_key_decoder_unit] OK");
		end else begin
			$display("[morse_key_decoder_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_cfg_regs.sv
hw/rtl/mkd_core.sv
hw/rtl/morse_key_decoder_unit.sv
sim/morse_key_decoder_unit_tb.sv
